[hw/rtl/mqtf_pkg.sv]
package mqtf_pkg;

    localparam int TASK_COUNT_DEF = 64;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

endpackage

[hw/rtl/mqtf_ram.sv]
module mqtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/multi_queue_task_fifo.sv]
// A request with an out-of-range task gives its result straight from the idle state,
// a push to an empty queue or a pop of an empty queue from the queue read state, any
// other push from the second link write state and any other pop from the link read
// state; busy is high from the queue read state until done rises.
// A new request is taken only in idle, after the read, modify and write back of the
// queue and link memories. After reset a clearing pass empties every queue; busy stays
// high. Each result is strobed by done for one cycle; the receiver cannot stall.
module multi_queue_task_fifo #(
    parameter int TASK_COUNT = mqtf_pkg::TASK_COUNT_DEF,
    localparam int ID_W  = $clog2(TASK_COUNT),
    localparam int CNT_W = $clog2(TASK_COUNT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             func,
    input  logic [ID_W-1:0]  owner_task,
    input  logic [ID_W-1:0]  entry_task,
    output logic             done,
    output logic             ok,
    output logic [ID_W-1:0]  popped_task,
    output logic [CNT_W-1:0] queue_length
);

    localparam int QW = CNT_W + 2 * ID_W;
    localparam int LW = ID_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READQ = 3'd2;
    localparam logic [2:0] ST_READL = 3'd3;
    localparam logic [2:0] ST_LINK2 = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [ID_W-1:0]  clr_reg, clr_next;
    logic             done_reg, done_next;
    logic             ok_reg, ok_next;
    logic [ID_W-1:0]  popped_reg, popped_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             func_reg, func_next;
    logic [ID_W-1:0]  owner_reg, owner_next;
    logic [ID_W-1:0]  entry_reg, entry_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  old_reg, old_next;
    logic [ID_W-1:0]  new_reg, new_next;

    logic             q_we;
    logic [ID_W-1:0]  q_waddr, q_raddr;
    logic [QW-1:0]    q_wdata, q_rdata;
    logic             l_we;
    logic [ID_W-1:0]  l_waddr, l_raddr;
    logic [LW-1:0]    l_wdata, l_rdata;

    logic [CNT_W-1:0] q_cnt, cnt_sat, cnt_dec;
    logic [ID_W-1:0]  q_old, q_new, l_nxt;
    logic             l_v;
    logic             bad_req;

    mqtf_ram #(
        .WIDTH (QW),
        .DEPTH (TASK_COUNT)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mqtf_ram #(
        .WIDTH (LW),
        .DEPTH (TASK_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign q_cnt = q_rdata[QW-1 -: CNT_W];
    assign q_old = q_rdata[2*ID_W-1:ID_W];
    assign q_new = q_rdata[ID_W-1:0];
    assign l_v   = l_rdata[ID_W];
    assign l_nxt = l_rdata[ID_W-1:0];

    assign cnt_sat = (q_cnt < CNT_W'(TASK_COUNT)) ? q_cnt + CNT_W'(1) : q_cnt;
    assign cnt_dec = cnt_reg - CNT_W'(1);

    assign bad_req = ({1'b0, owner_task} >= (ID_W + 1)'(TASK_COUNT))
                  || ((func == mqtf_pkg::FUNC_PUSH)
                      && ({1'b0, entry_task} >= (ID_W + 1)'(TASK_COUNT)));

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        popped_next = popped_reg;
        len_next    = len_reg;
        func_next   = func_reg;
        owner_next  = owner_reg;
        entry_next  = entry_reg;
        cnt_next    = cnt_reg;
        old_next    = old_reg;
        new_next    = new_reg;
        q_we        = 1'b0;
        q_waddr     = owner_reg;
        q_wdata     = '0;
        q_raddr     = owner_task;
        l_we        = 1'b0;
        l_waddr     = entry_reg;
        l_wdata     = '0;
        l_raddr     = q_old;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep every queue to empty
                q_we     = 1'b1;
                q_waddr  = clr_reg;
                clr_next = clr_reg + ID_W'(1);
                if (clr_reg == ID_W'(TASK_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    owner_next = owner_task;
                    entry_next = entry_task;
                    if (bad_req)
                    begin
                        done_next   = 1'b1;
                        ok_next     = 1'b0;
                        popped_next = '0;
                        len_next    = '0;
                    end
                    else
                    begin
                        state_next = ST_READQ;
                    end
                end
            end
            ST_READQ:
            begin
                cnt_next = q_cnt;
                old_next = q_old;
                new_next = q_new;
                if (func_reg == mqtf_pkg::FUNC_PUSH)
                begin
                    q_we = 1'b1;
                    if (q_cnt == '0)
                    begin
                        q_wdata     = {CNT_W'(1), entry_reg, entry_reg};
                        l_we        = 1'b1;
                        done_next   = 1'b1;
                        ok_next     = 1'b1;
                        popped_next = '0;
                        len_next    = CNT_W'(1);
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        // append behind the newest entry, clear the new entry's link next
                        q_wdata    = {cnt_sat, q_old, entry_reg};
                        l_we       = 1'b1;
                        l_waddr    = q_new;
                        l_wdata    = {1'b1, entry_reg};
                        len_next   = cnt_sat;
                        state_next = ST_LINK2;
                    end
                end
                else
                begin
                    if (q_cnt == '0)
                    begin
                        done_next   = 1'b1;
                        ok_next     = 1'b0;
                        popped_next = '0;
                        len_next    = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READL;
                    end
                end
            end
            ST_LINK2:
            begin
                l_we        = 1'b1;
                done_next   = 1'b1;
                ok_next     = 1'b1;
                popped_next = '0;
                state_next  = ST_IDLE;
            end
            ST_READL:
            begin
                q_we        = 1'b1;
                l_we        = 1'b1;
                l_waddr     = old_reg;
                l_wdata     = {1'b0, l_nxt};
                done_next   = 1'b1;
                ok_next     = 1'b1;
                popped_next = old_reg;
                if (l_v && (cnt_dec != '0))
                begin
                    q_wdata  = {cnt_dec, l_nxt, new_reg};
                    len_next = cnt_dec;
                end
                else
                begin
                    // end of chain or count run out: drop the queue to empty
                    q_wdata  = '0;
                    len_next = l_v ? cnt_dec : '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        popped_reg <= popped_next;
        len_reg    <= len_next;
        func_reg   <= func_next;
        owner_reg  <= owner_next;
        entry_reg  <= entry_next;
        cnt_reg    <= cnt_next;
        old_reg    <= old_next;
        new_reg    <= new_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign popped_task  = popped_reg;
    assign queue_length = len_reg;

endmodule

[test/multi_queue_task_fifo_tb.sv]
`timescale 1ns / 1ps

module multi_queue_task_fifo_tb;

    localparam int TASKS       = mqtf_pkg::TASK_COUNT_DEF;
    localparam int ID_W        = $clog2(TASKS);
    localparam int CNT_W       = $clog2(TASKS + 1);
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_REQS = 1650;

    typedef struct {
        logic            func;
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] entry;
        bit              hold;
    } request_t;

    typedef struct {
        logic             ok;
        logic [ID_W-1:0]  task_id;
        logic [CNT_W-1:0] length;
    } outcome_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             start      = 1'b0;
    logic             func       = mqtf_pkg::FUNC_PUSH;
    logic [ID_W-1:0]  owner_task = '0;
    logic [ID_W-1:0]  entry_task = '0;
    logic             busy;
    logic             done;
    logic             ok;
    logic [ID_W-1:0]  popped_task;
    logic [CNT_W-1:0] queue_length;

    // copy 0 steers request generation, copy 1 predicts the block
    bit [ID_W-1:0]  newest_task [2][TASKS];
    bit [ID_W-1:0]  oldest_task [2][TASKS];
    bit [CNT_W-1:0] queue_len   [2][TASKS];
    bit [ID_W-1:0]  next_task   [2][TASKS];
    bit             next_ok     [2][TASKS];
    bit             task_queued [TASKS];

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    request_t presented;
    int       total_requests = 0;
    int       issued         = 0;
    int       received       = 0;
    int       mismatches     = 0;
    int       stall_cycles   = 0;

    multi_queue_task_fifo #(
        .TASK_COUNT(TASKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .owner_task(owner_task),
        .entry_task(entry_task),
        .done(done),
        .ok(ok),
        .popped_task(popped_task),
        .queue_length(queue_length)
    );

    always #5 clk = ~clk;

    function automatic outcome_t apply_queue_op(int c, request_t r);
        outcome_t        res;
        bit [ID_W-1:0]   head;
        res.ok      = 1'b0;
        res.task_id = '0;
        res.length  = '0;
        if (r.func == mqtf_pkg::FUNC_PUSH)
        begin
            if (queue_len[c][r.owner] == 0)
            begin
                oldest_task[c][r.owner] = r.entry;
            end
            else
            begin
                next_task[c][newest_task[c][r.owner]] = r.entry;
                next_ok[c][newest_task[c][r.owner]]   = 1'b1;
            end
            next_ok[c][r.entry]     = 1'b0;
            newest_task[c][r.owner] = r.entry;
            if (queue_len[c][r.owner] < TASKS)
                queue_len[c][r.owner]++;
            res.ok     = 1'b1;
            res.length = queue_len[c][r.owner];
        end
        else if (queue_len[c][r.owner] != 0)
        begin
            head = oldest_task[c][r.owner];
            if (next_ok[c][head])
            begin
                oldest_task[c][r.owner] = next_task[c][head];
                queue_len[c][r.owner]--;
            end
            else
            begin
                // end of chain: the queue empties whatever its count
                queue_len[c][r.owner] = '0;
            end
            next_ok[c][head] = 1'b0;
            if (queue_len[c][r.owner] == 0)
            begin
                oldest_task[c][r.owner] = '0;
                newest_task[c][r.owner] = '0;
            end
            res.ok      = 1'b1;
            res.task_id = head;
            res.length  = queue_len[c][r.owner];
        end
        return res;
    endfunction

    function automatic void add_request(logic f, int owner, int entry, bit hold);
        request_t r;
        outcome_t res;
        r.func  = f;
        r.owner = owner[ID_W-1:0];
        r.entry = entry[ID_W-1:0];
        r.hold  = hold;
        res = apply_queue_op(0, r);
        if (f == mqtf_pkg::FUNC_PUSH)
            task_queued[r.entry] = 1'b1;
        else if (res.ok)
            task_queued[res.task_id] = 1'b0;
        pending_requests.push_back(r);
    endfunction

    function automatic int pick_free_task();
        int t;
        for (int i = 0; i < 4 * TASKS; i++)
        begin
            t = $urandom_range(0, TASKS - 1);
            if (!task_queued[t])
                return t;
        end
        return $urandom_range(0, TASKS - 1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        outcome_t predicted;
        bit       presenting;
        int       idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            presenting = start;
            if (start && !busy)
            begin
                predicted = apply_queue_op(1, presented);
                expected_outcomes.push_back(predicted);
                issued++;
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                idle_pct = (issued < total_requests / 3) ? 16 :
                           (issued < 2 * total_requests / 3) ? 57 : 0;
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                    (!pending_requests[0].hold || issued == received))
                begin
                    presented = pending_requests.pop_front();
                    func       <= presented.func;
                    owner_task <= presented.owner;
                    entry_task <= presented.entry;
                    start      <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            received <= received + 1;
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("result ok=%0b task=%0d len=%0d with none outstanding",
                                          ok, popped_task, queue_length));
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (ok !== want.ok)
                    report_mismatch($sformatf("ok %0b, expected %0b", ok, want.ok));
                if (popped_task !== want.task_id)
                    report_mismatch($sformatf("popped_task %0d, expected %0d",
                                              popped_task, want.task_id));
                if (queue_length !== want.length)
                    report_mismatch($sformatf("queue_length %0d, expected %0d",
                                              queue_length, want.length));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin : run
        int  pick;
        int  n_owners;
        int  steps;
        int  pop_pct;
        int  o;
        int  sat_runs;
        int  owners[3];
        bit  hold;
        bit  all_empty;
        sat_runs = 0;

        add_request(mqtf_pkg::FUNC_PUSH, 0, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, 0, TASKS - 1, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 0, TASKS - 1, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 0, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 0, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, TASKS - 1, TASKS - 1, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, TASKS - 1, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, TASKS - 1, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, 42, 21, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, 21, 42, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 42, 21, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 21, 42, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, TASKS - 1, TASKS - 1, 1'b0);
        // re-push of a queued task breaks the owner's chain
        add_request(mqtf_pkg::FUNC_PUSH, 1, 1, 1'b1);
        add_request(mqtf_pkg::FUNC_PUSH, 1, 2, 1'b0);
        add_request(mqtf_pkg::FUNC_PUSH, 2, 1, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 1, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 1, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 2, 0, 1'b0);
        add_request(mqtf_pkg::FUNC_POP, 2, 0, 1'b0);

        while (pending_requests.size() < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if ((pick < 3 || sat_runs == 0) && sat_runs < 4)
            begin
                // fill one queue past its limit, then empty it
                sat_runs++;
                o = $urandom_range(0, TASKS - 1);
                for (int i = 0; i < TASKS + 4; i++)
                    add_request(mqtf_pkg::FUNC_PUSH, o, pick_free_task(), 1'b0);
                while (queue_len[0][o] != 0)
                    add_request(mqtf_pkg::FUNC_POP, o, $urandom_range(0, TASKS - 1), 1'b0);
            end
            else if (pick < 63)
            begin
                n_owners = $urandom_range(1, 3);
                for (int i = 0; i < 3; i++)
                    owners[i] = $urandom_range(0, TASKS - 1);
                pop_pct = $urandom_range(25, 60);
                steps = $urandom_range(4, 24);
                for (int i = 0; i < steps; i++)
                begin
                    o = owners[$urandom_range(0, n_owners - 1)];
                    if ($urandom_range(0, 99) < pop_pct)
                        add_request(mqtf_pkg::FUNC_POP, o, $urandom_range(0, TASKS - 1), 1'b0);
                    else
                        add_request(mqtf_pkg::FUNC_PUSH, o, pick_free_task(), 1'b0);
                end
            end
            else if (pick < 78)
            begin
                // drain every queue, holding off until the block has caught up
                hold = 1'b1;
                for (int t = 0; t < TASKS; t++)
                begin
                    while (queue_len[0][t] != 0)
                    begin
                        add_request(mqtf_pkg::FUNC_POP, t, $urandom_range(0, TASKS - 1), hold);
                        hold = 1'b0;
                    end
                end
            end
            else
            begin
                steps = $urandom_range(1, 8);
                for (int i = 0; i < steps; i++)
                    add_request(1'($urandom_range(0, 1)), $urandom_range(0, TASKS - 1),
                                $urandom_range(0, TASKS - 1), $urandom_range(0, 99) == 0);
            end
            all_empty = 1'b1;
            for (int t = 0; t < TASKS; t++)
                if (queue_len[0][t] != 0)
                    all_empty = 1'b0;
            if (all_empty)
                for (int t = 0; t < TASKS; t++)
                    task_queued[t] = 1'b0;
        end
        total_requests = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || issued != received);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
